### src/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int LEVELS_DEF   = 3;
    localparam int CAPACITY_DEF = 64;

    // Width used when levels in use are compared with the 2-bit level fields.
    localparam int NLW = 4;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_DROP   = 3'd1;
    localparam logic [2:0] KIND_SERVE  = 3'd2;
    localparam logic [2:0] KIND_MOVE   = 3'd3;
    localparam logic [2:0] KIND_XFER   = 3'd4;
    localparam logic [2:0] KIND_STAT   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_LVL = 2'd3;

    localparam logic [1:0] SRC_DIRECT = 2'd0;
    localparam logic [1:0] SRC_XFER   = 2'd1;

    localparam int CNT_DIRECT    = 0;
    localparam int CNT_MOVED_IN  = 1;
    localparam int CNT_XFER_IN   = 2;
    localparam int CNT_SERVED    = 3;
    localparam int CNT_DROPPED   = 4;
    localparam int CNT_MOVED_OUT = 5;
    localparam int CNT_PER_LEVEL = 6;

    localparam int SUM_SERVED    = 0;
    localparam int SUM_DROPPED   = 1;
    localparam int SUM_MOVED     = 2;
    localparam int SUM_PER_LEVEL = 3;

    localparam logic [3:0] SEL_FIRST_SUM = 4'd6;
    localparam logic [3:0] SEL_END       = 4'd9;

    localparam logic REG_NUM_LEVELS   = 1'b0;
    localparam logic REG_LEVEL_BY_AGE = 1'b1;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] item_id;
        logic [1:0]  age_class;
        logic [1:0]  severity;
        logic [1:0]  source;
        logic [1:0]  level_from;
        logic [1:0]  level_to;
        logic [31:0] time_now;
        logic [3:0]  stat_select;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  level;
        logic [15:0] result_id;
        logic [6:0]  occupancy;
        logic [47:0] stat_value;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FREE,
        S_WRITE,
        S_LINK,
        S_WALK_RD,
        S_WALK_CHK,
        S_SRV_RD,
        S_SRV_DO,
        S_SUM,
        S_CNT,
        S_STAT,
        S_DONE
    } state_t;

endpackage

### src/strict_priority_queue_with_stats.sv
`timescale 1ns / 1ps

// Strict priority multi-queue with per-level statistics.
// Commands arrive as beats on the req channel (valid/ready) and each one gives
// exactly one beat on the rsp channel. A small sequencer steps one command at a
// time through the slot memories and a shared counter and sum adder; req_ready
// is high only while the sequencer is idle.
// Insert time is set by the one-slot-a-cycle free slot scan; drop and move
// walk the level list entry by entry (up to CAPACITY entries) through the
// single read port of the slot memories.
// The result sits in an output register, so the next command is taken while
// an earlier result still waits; the sequencer holds its final step only if
// the receiver stalls a second result behind the first.
// Reset empties every level, clears the slot used bits, the counters and the
// wait sums, and sets three levels chosen by severity. No clearing pass runs.
// The APB port holds num_levels at 0x0 and level_by_age at 0x4; the user must
// write it only while no command is in flight; the block does not enforce this.
module strict_priority_queue_with_stats #(
    parameter int LEVELS   = spq_pkg::LEVELS_DEF,
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          req_valid,
    output logic          req_ready,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spq_pkg::rsp_t rsp
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW   = $clog2(CAPACITY + 1);
    localparam int LIW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NCNT = LEVELS * spq_pkg::CNT_PER_LEVEL;
    localparam int NSUM = LEVELS * spq_pkg::SUM_PER_LEVEL;
    localparam int CIW  = $clog2(NCNT);
    localparam int SIW  = $clog2(NSUM);
    localparam logic [SW-1:0] NIL = SW'(CAPACITY);

    spq_pkg::state_t state_reg, state_next;

    logic [15:0]   tag_mem  [CAPACITY];
    logic [31:0]   time_mem [CAPACITY];
    logic [SW-1:0] link_mem [CAPACITY];
    logic [15:0]   tag_rd_reg;
    logic [31:0]   time_rd_reg;
    logic [SW-1:0] link_rd_reg;

    logic [CAPACITY-1:0] used_reg;
    logic [SW-1:0]       head_reg  [LEVELS];
    logic [SW-1:0]       tail_reg  [LEVELS];
    logic [SW-1:0]       count_reg [LEVELS];
    logic [31:0]         cnt_reg   [NCNT];
    logic [47:0]         sum_reg   [NSUM];

    logic [1:0]    num_levels_reg;
    logic          by_age_reg;

    spq_pkg::req_t req_reg;
    logic [1:0]    status_reg;
    logic [1:0]    lvl_reg;
    logic [15:0]   rid_reg;
    logic [47:0]   sv_reg;
    logic          show_reg;
    logic [SW-1:0] cur_reg;
    logic [SW-1:0] prev_reg;
    logic [SW-1:0] steps_reg;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] scan_reg;
    logic [31:0]   wait_reg;
    logic [CIW-1:0] cnt_idx_reg;
    logic [CIW-1:0] cnt2_idx_reg;
    logic           cnt2_pend_reg;
    logic [SIW-1:0] sum_idx_reg;

    spq_pkg::rsp_t rsp_reg;
    logic          rsp_valid_reg;

    logic [spq_pkg::NLW-1:0] nl;
    logic [1:0]     lvl_ins;
    logic [LIW-1:0] ins_i, lf_i, lt_i, app_i;
    logic           ins_bad, lf_bad, lt_bad;
    logic           srv_found;
    logic [LIW-1:0] srv_i;
    logic           match;
    logic           link_we;
    logic [AW-1:0]  link_wa;
    logic [SW-1:0]  link_wd;
    logic [CIW-1:0] cnt_rd_idx;
    logic [SIW-1:0] sum_rd_idx;
    logic [31:0]    cnt_rd;
    logic [47:0]    sum_rd;
    logic [48:0]    sum_add;
    logic [47:0]    sum_sat;
    logic [10:0]    occ_wide;
    logic [6:0]     occ;
    logic           cfg_wr;
    logic           rsp_free;
    logic [SW-1:0]  total_count;

    function automatic logic [CIW-1:0] cidx(input logic [LIW-1:0] l, input int k);
        return CIW'(int'(l) * spq_pkg::CNT_PER_LEVEL + k);
    endfunction

    function automatic logic [SIW-1:0] sidx(input logic [LIW-1:0] l, input int k);
        return SIW'(int'(l) * spq_pkg::SUM_PER_LEVEL + k);
    endfunction

    // Levels in use: zero acts as one, anything above LEVELS as LEVELS.
    always_comb
    begin
        if (num_levels_reg == 2'd0)
        begin
            nl = spq_pkg::NLW'(1);
        end
        else if ({2'b00, num_levels_reg} > spq_pkg::NLW'(LEVELS))
        begin
            nl = spq_pkg::NLW'(LEVELS);
        end
        else
        begin
            nl = {2'b00, num_levels_reg};
        end
    end

    always_comb
    begin
        if (nl == spq_pkg::NLW'(1))
        begin
            lvl_ins = 2'd0;
        end
        else if (by_age_reg)
        begin
            lvl_ins = req_reg.age_class;
        end
        else
        begin
            lvl_ins = req_reg.severity;
        end
    end

    assign ins_i   = LIW'(lvl_ins);
    assign lf_i    = LIW'(req_reg.level_from);
    assign lt_i    = LIW'(req_reg.level_to);
    assign app_i   = LIW'(lvl_reg);
    assign ins_bad = {2'b00, lvl_ins} >= nl;
    assign lf_bad  = {2'b00, req_reg.level_from} >= nl;
    assign lt_bad  = {2'b00, req_reg.level_to} >= nl;
    assign match   = tag_rd_reg == req_reg.item_id;

    always_comb
    begin
        srv_found = 1'b0;
        srv_i     = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (!srv_found && (spq_pkg::NLW'(i) < nl) && (head_reg[i] != NIL))
            begin
                srv_found = 1'b1;
                srv_i     = LIW'(i);
            end
        end
    end

    // One read index each for the counter and sum arrays, shared by update and read-out.
    always_comb
    begin
        cnt_rd_idx = cnt_idx_reg;
        sum_rd_idx = sum_idx_reg;
        if (state_reg == spq_pkg::S_STAT)
        begin
            if (req_reg.stat_select < spq_pkg::SEL_FIRST_SUM)
            begin
                cnt_rd_idx = cidx(lf_i, int'(req_reg.stat_select));
            end
            else if (req_reg.stat_select < spq_pkg::SEL_END)
            begin
                sum_rd_idx = sidx(lf_i, int'(req_reg.stat_select - spq_pkg::SEL_FIRST_SUM));
            end
        end
    end

    assign cnt_rd  = cnt_reg[cnt_rd_idx];
    assign sum_rd  = sum_reg[sum_rd_idx];
    assign sum_add = {1'b0, sum_rd} + {17'd0, wait_reg};
    assign sum_sat = sum_add[48] ? spq_pkg::SUM_MAX : sum_add[47:0];

    always_comb
    begin
        occ_wide = '0;
        if (show_reg && ({2'b00, lvl_reg} < spq_pkg::NLW'(LEVELS)))
        begin
            occ_wide = 11'(count_reg[app_i]);
        end
        occ = occ_wide[6:0];
    end

    assign rsp_free = !rsp_valid_reg || rsp_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = spq_pkg::S_DECODE;
                end
            end
            spq_pkg::S_DECODE:
            begin
                case (req_reg.kind)
                    spq_pkg::KIND_INSERT:
                        state_next = ins_bad ? spq_pkg::S_DONE : spq_pkg::S_FREE;
                    spq_pkg::KIND_DROP:
                        state_next = lf_bad ? spq_pkg::S_DONE : spq_pkg::S_WALK_RD;
                    spq_pkg::KIND_SERVE:
                        state_next = srv_found ? spq_pkg::S_SRV_RD : spq_pkg::S_DONE;
                    spq_pkg::KIND_MOVE:
                        state_next = (lf_bad || lt_bad) ? spq_pkg::S_DONE : spq_pkg::S_WALK_RD;
                    spq_pkg::KIND_XFER:
                        state_next = lf_bad ? spq_pkg::S_DONE : spq_pkg::S_CNT;
                    spq_pkg::KIND_STAT:
                        state_next = lf_bad ? spq_pkg::S_DONE : spq_pkg::S_STAT;
                    default:
                        state_next = spq_pkg::S_DONE;
                endcase
            end
            spq_pkg::S_FREE:
            begin
                if (!used_reg[scan_reg])
                begin
                    state_next = spq_pkg::S_WRITE;
                end
                else if (scan_reg == AW'(CAPACITY - 1))
                begin
                    state_next = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_WRITE:
                state_next = spq_pkg::S_LINK;
            spq_pkg::S_LINK:
            begin
                if (req_reg.kind == spq_pkg::KIND_INSERT
                    && (req_reg.source == spq_pkg::SRC_DIRECT
                        || req_reg.source == spq_pkg::SRC_XFER))
                begin
                    state_next = spq_pkg::S_CNT;
                end
                else
                begin
                    state_next = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_WALK_RD:
            begin
                if (cur_reg >= NIL || steps_reg == NIL)
                begin
                    state_next = spq_pkg::S_DONE;
                end
                else
                begin
                    state_next = spq_pkg::S_WALK_CHK;
                end
            end
            spq_pkg::S_WALK_CHK:
                state_next = match ? spq_pkg::S_SUM : spq_pkg::S_WALK_RD;
            spq_pkg::S_SRV_RD:
                state_next = spq_pkg::S_SRV_DO;
            spq_pkg::S_SRV_DO:
                state_next = spq_pkg::S_SUM;
            spq_pkg::S_SUM:
                state_next = spq_pkg::S_CNT;
            spq_pkg::S_CNT:
            begin
                if (!cnt2_pend_reg)
                begin
                    state_next = (req_reg.kind == spq_pkg::KIND_MOVE)
                                 ? spq_pkg::S_WRITE : spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_STAT:
                state_next = spq_pkg::S_DONE;
            spq_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
                state_next = spq_pkg::S_IDLE;
        endcase
    end

    // Handshake and link memory write port.
    always_comb
    begin
        req_ready = state_reg == spq_pkg::S_IDLE;
        link_we   = 1'b0;
        link_wa   = slot_reg;
        link_wd   = NIL;
        case (state_reg)
            spq_pkg::S_WALK_CHK:
            begin
                if (match && prev_reg != NIL)
                begin
                    link_we = 1'b1;
                    link_wa = prev_reg[AW-1:0];
                    link_wd = link_rd_reg;
                end
            end
            spq_pkg::S_WRITE:
            begin
                link_we = 1'b1;
            end
            spq_pkg::S_LINK:
            begin
                if (head_reg[app_i] != NIL)
                begin
                    link_we = 1'b1;
                    link_wa = tail_reg[app_i][AW-1:0];
                    link_wd = SW'(slot_reg);
                end
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (paddr[2])
            spq_pkg::REG_NUM_LEVELS: prdata = {30'd0, num_levels_reg};
            default:                 prdata = {31'd0, by_age_reg};
        endcase
    end

    assign pready    = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Slot memories: registered read at the current walk position.
    always_ff @(posedge clk)
    begin
        tag_rd_reg  <= tag_mem[cur_reg[AW-1:0]];
        time_rd_reg <= time_mem[cur_reg[AW-1:0]];
        link_rd_reg <= link_mem[cur_reg[AW-1:0]];
        if (state_reg == spq_pkg::S_WRITE)
        begin
            tag_mem[slot_reg]  <= req_reg.item_id;
            time_mem[slot_reg] <= req_reg.time_now;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
    end

    // Command payload and working registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    req_reg <= req;
                end
            end
            spq_pkg::S_DECODE:
            begin
                sv_reg    <= '0;
                prev_reg  <= NIL;
                steps_reg <= '0;
                scan_reg  <= '0;
                case (req_reg.kind)
                    spq_pkg::KIND_INSERT:
                    begin
                        lvl_reg       <= lvl_ins;
                        rid_reg       <= req_reg.item_id;
                        show_reg      <= !ins_bad;
                        status_reg    <= ins_bad ? spq_pkg::ST_BAD_LVL : spq_pkg::ST_OK;
                        cnt2_pend_reg <= 1'b0;
                        cnt_idx_reg   <= cidx(ins_i, (req_reg.source == spq_pkg::SRC_XFER)
                                              ? spq_pkg::CNT_XFER_IN : spq_pkg::CNT_DIRECT);
                    end
                    spq_pkg::KIND_DROP:
                    begin
                        lvl_reg       <= req_reg.level_from;
                        rid_reg       <= '0;
                        show_reg      <= !lf_bad;
                        status_reg    <= lf_bad ? spq_pkg::ST_BAD_LVL : spq_pkg::ST_OK;
                        cur_reg       <= head_reg[lf_i];
                        cnt2_pend_reg <= 1'b0;
                        sum_idx_reg   <= sidx(lf_i, spq_pkg::SUM_DROPPED);
                        cnt_idx_reg   <= cidx(lf_i, spq_pkg::CNT_DROPPED);
                    end
                    spq_pkg::KIND_SERVE:
                    begin
                        lvl_reg       <= 2'(srv_i);
                        rid_reg       <= '0;
                        show_reg      <= srv_found;
                        status_reg    <= srv_found ? spq_pkg::ST_OK : spq_pkg::ST_MISS;
                        cur_reg       <= head_reg[srv_i];
                        cnt2_pend_reg <= 1'b0;
                        sum_idx_reg   <= sidx(srv_i, spq_pkg::SUM_SERVED);
                        cnt_idx_reg   <= cidx(srv_i, spq_pkg::CNT_SERVED);
                    end
                    spq_pkg::KIND_MOVE:
                    begin
                        lvl_reg       <= lf_bad ? req_reg.level_from : req_reg.level_to;
                        rid_reg       <= '0;
                        show_reg      <= !(lf_bad || lt_bad);
                        status_reg    <= (lf_bad || lt_bad) ? spq_pkg::ST_BAD_LVL
                                                            : spq_pkg::ST_OK;
                        cur_reg       <= head_reg[lf_i];
                        sum_idx_reg   <= sidx(lf_i, spq_pkg::SUM_MOVED);
                        cnt_idx_reg   <= cidx(lf_i, spq_pkg::CNT_MOVED_OUT);
                        cnt2_idx_reg  <= cidx(lt_i, spq_pkg::CNT_MOVED_IN);
                        cnt2_pend_reg <= 1'b1;
                    end
                    spq_pkg::KIND_XFER:
                    begin
                        lvl_reg       <= req_reg.level_from;
                        rid_reg       <= '0;
                        show_reg      <= !lf_bad;
                        status_reg    <= lf_bad ? spq_pkg::ST_BAD_LVL : spq_pkg::ST_OK;
                        cnt_idx_reg   <= cidx(lf_i, spq_pkg::CNT_XFER_IN);
                        cnt2_idx_reg  <= cidx(lf_i, spq_pkg::CNT_DROPPED);
                        cnt2_pend_reg <= 1'b1;
                    end
                    spq_pkg::KIND_STAT:
                    begin
                        lvl_reg       <= req_reg.level_from;
                        rid_reg       <= '0;
                        show_reg      <= !lf_bad;
                        status_reg    <= lf_bad ? spq_pkg::ST_BAD_LVL : spq_pkg::ST_OK;
                        cnt2_pend_reg <= 1'b0;
                    end
                    default:
                    begin
                        lvl_reg       <= 2'd0;
                        rid_reg       <= '0;
                        show_reg      <= 1'b0;
                        status_reg    <= spq_pkg::ST_OK;
                        cnt2_pend_reg <= 1'b0;
                    end
                endcase
            end
            spq_pkg::S_FREE:
            begin
                slot_reg <= scan_reg;
                scan_reg <= scan_reg + AW'(1);
                if (used_reg[scan_reg] && scan_reg == AW'(CAPACITY - 1))
                begin
                    status_reg <= spq_pkg::ST_FULL;
                end
            end
            spq_pkg::S_WALK_RD:
            begin
                if (cur_reg >= NIL || steps_reg == NIL)
                begin
                    status_reg <= spq_pkg::ST_MISS;
                end
            end
            spq_pkg::S_WALK_CHK:
            begin
                if (match)
                begin
                    slot_reg <= cur_reg[AW-1:0];
                    wait_reg <= req_reg.time_now - time_rd_reg;
                    rid_reg  <= req_reg.item_id;
                end
                else
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= link_rd_reg;
                    steps_reg <= steps_reg + SW'(1);
                end
            end
            spq_pkg::S_SRV_DO:
            begin
                wait_reg <= req_reg.time_now - time_rd_reg;
                rid_reg  <= tag_rd_reg;
            end
            spq_pkg::S_CNT:
            begin
                cnt_idx_reg   <= cnt2_idx_reg;
                cnt2_pend_reg <= 1'b0;
            end
            spq_pkg::S_STAT:
            begin
                if (req_reg.stat_select < spq_pkg::SEL_FIRST_SUM)
                begin
                    sv_reg <= {16'd0, cnt_rd};
                end
                else if (req_reg.stat_select < spq_pkg::SEL_END)
                begin
                    sv_reg <= sum_rd;
                end
            end
            spq_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_reg.status     <= status_reg;
                    rsp_reg.level      <= lvl_reg;
                    rsp_reg.result_id  <= rid_reg;
                    rsp_reg.occupancy  <= occ;
                    rsp_reg.stat_value <= sv_reg;
                end
            end
            default:
            begin
                wait_reg <= wait_reg;
            end
        endcase
    end

    // Control state: level lists, used bits, statistics, configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spq_pkg::S_IDLE;
            used_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            num_levels_reg <= 2'd3;
            by_age_reg     <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= NIL;
                tail_reg[i]  <= NIL;
                count_reg[i] <= '0;
            end
            for (int i = 0; i < NCNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            for (int i = 0; i < NSUM; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                case (paddr[2])
                    spq_pkg::REG_NUM_LEVELS: num_levels_reg <= pwdata[1:0];
                    default:                 by_age_reg     <= pwdata[0];
                endcase
            end
            if (state_reg == spq_pkg::S_DONE && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                spq_pkg::S_WRITE:
                begin
                    used_reg[slot_reg] <= 1'b1;
                end
                spq_pkg::S_LINK:
                begin
                    if (head_reg[app_i] == NIL)
                    begin
                        head_reg[app_i] <= SW'(slot_reg);
                    end
                    tail_reg[app_i]  <= SW'(slot_reg);
                    count_reg[app_i] <= count_reg[app_i] + SW'(1);
                end
                spq_pkg::S_WALK_CHK:
                begin
                    if (match)
                    begin
                        if (prev_reg == NIL)
                        begin
                            head_reg[lf_i] <= link_rd_reg;
                        end
                        if (tail_reg[lf_i] == cur_reg)
                        begin
                            tail_reg[lf_i] <= prev_reg;
                        end
                        count_reg[lf_i] <= count_reg[lf_i] - SW'(1);
                        if (req_reg.kind == spq_pkg::KIND_DROP)
                        begin
                            used_reg[cur_reg[AW-1:0]] <= 1'b0;
                        end
                    end
                end
                spq_pkg::S_SRV_DO:
                begin
                    head_reg[app_i] <= link_rd_reg;
                    if (link_rd_reg == NIL)
                    begin
                        tail_reg[app_i] <= NIL;
                    end
                    count_reg[app_i]          <= count_reg[app_i] - SW'(1);
                    used_reg[cur_reg[AW-1:0]] <= 1'b0;
                end
                spq_pkg::S_SUM:
                begin
                    sum_reg[sum_idx_reg] <= sum_sat;
                end
                spq_pkg::S_CNT:
                begin
                    cnt_reg[cnt_idx_reg] <= cnt_rd + 32'd1;
                end
                default:
                begin
                    used_reg <= used_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        total_count = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            total_count = total_count + count_reg[i];
        end
    end

`ifndef SYNTHESIS
    // Between commands the list counts must agree with the slots marked used.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::S_IDLE) |-> ($countones(used_reg) == int'(total_count)))
        else $error("level counts disagree with used slots");

    // A result beat only appears out of the final sequencer step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == spq_pkg::S_DONE))
        else $error("result raised outside the final step");

    // The list walk never runs past the capacity of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::S_WALK_CHK) |-> (steps_reg < NIL && cur_reg < NIL))
        else $error("list walk out of range");
`endif

endmodule

### tb/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    input  logic          req_valid,
    input  logic          req_ready,
    input  spq_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  spq_pkg::rsp_t rsp,
    output int            errors,
    output int            pending
);

    localparam int NSLOT = spq_pkg::CAPACITY_DEF;
    localparam int NLVL  = spq_pkg::LEVELS_DEF;
    localparam int NCPL  = spq_pkg::CNT_PER_LEVEL;
    localparam int NSPL  = spq_pkg::SUM_PER_LEVEL;
    localparam logic [6:0] NO_SLOT = 7'(NSLOT);
    localparam logic [2:0] ADDR_NUM_LEVELS = {spq_pkg::REG_NUM_LEVELS, 2'b00};
    localparam logic [2:0] ADDR_BY_AGE     = {spq_pkg::REG_LEVEL_BY_AGE, 2'b00};

    logic [15:0] tag     [NSLOT];
    logic [31:0] entered [NSLOT];
    logic [6:0]  nxt     [NSLOT];
    logic        busy    [NSLOT];
    logic [6:0]  head    [NLVL];
    logic [6:0]  tail    [NLVL];
    logic [6:0]  depth   [NLVL];
    logic [31:0] counts  [NLVL*NCPL];
    logic [47:0] waits   [NLVL*NSPL];
    logic [1:0]  lvl_reg;
    logic        age_reg;
    spq_pkg::rsp_t awaited [$];

    assign pending = awaited.size();

    function automatic void clear_model();
        for (int i = 0; i < NSLOT; i++) busy[i] = 1'b0;
        for (int i = 0; i < NLVL; i++)
        begin
            head[i] = NO_SLOT;
            tail[i] = NO_SLOT;
            depth[i] = '0;
        end
        for (int i = 0; i < NLVL*NCPL; i++) counts[i] = '0;
        for (int i = 0; i < NLVL*NSPL; i++) waits[i] = '0;
        lvl_reg = 2'd3;
        age_reg = 1'b0;
    endfunction

    function automatic void push_tail(int lv, logic [6:0] s);
        nxt[s] = NO_SLOT;
        if (head[lv] == NO_SLOT) head[lv] = s;
        else nxt[tail[lv]] = s;
        tail[lv] = s;
        depth[lv] = depth[lv] + 7'd1;
    endfunction

    // Unlinks the first entry with this id, nearest the head; NO_SLOT if absent.
    function automatic logic [6:0] unlink_id(int lv, logic [15:0] id);
        logic [6:0] prev;
        logic [6:0] cur;
        prev = NO_SLOT;
        cur = head[lv];
        while (cur != NO_SLOT)
        begin
            if (tag[cur] == id)
            begin
                if (prev == NO_SLOT) head[lv] = nxt[cur];
                else nxt[prev] = nxt[cur];
                if (tail[lv] == cur) tail[lv] = prev;
                depth[lv] = depth[lv] - 7'd1;
                return cur;
            end
            prev = cur;
            cur = nxt[cur];
        end
        return NO_SLOT;
    endfunction

    function automatic void add_wait(int idx, logic [31:0] w);
        logic [48:0] v;
        v = {1'b0, waits[idx]} + 49'(w);
        waits[idx] = (v > 49'(spq_pkg::SUM_MAX)) ? spq_pkg::SUM_MAX : v[47:0];
    endfunction

    function automatic spq_pkg::rsp_t queue_outcome(spq_pkg::req_t r);
        spq_pkg::rsp_t o;
        int nl;
        int lv;
        int s;
        logic show;
        o = '0;
        show = 1'b0;
        nl = (lvl_reg == 2'd0) ? 1 : int'(lvl_reg);
        case (r.kind)
            spq_pkg::KIND_INSERT:
            begin
                lv = (nl == 1) ? 0 : (age_reg ? int'(r.age_class) : int'(r.severity));
                o.level = 2'(lv);
                o.result_id = r.item_id;
                if (lv >= nl) o.status = spq_pkg::ST_BAD_LVL;
                else
                begin
                    show = 1'b1;
                    s = 0;
                    while (s < NSLOT && busy[s]) s++;
                    if (s >= NSLOT) o.status = spq_pkg::ST_FULL;
                    else
                    begin
                        busy[s] = 1'b1;
                        tag[s] = r.item_id;
                        entered[s] = r.time_now;
                        push_tail(lv, 7'(s));
                        if (r.source == spq_pkg::SRC_XFER)
                            counts[lv*NCPL+spq_pkg::CNT_XFER_IN]++;
                        else if (r.source == spq_pkg::SRC_DIRECT)
                            counts[lv*NCPL+spq_pkg::CNT_DIRECT]++;
                    end
                end
            end
            spq_pkg::KIND_DROP:
            begin
                lv = int'(r.level_from);
                o.level = r.level_from;
                if (lv >= nl) o.status = spq_pkg::ST_BAD_LVL;
                else
                begin
                    show = 1'b1;
                    s = int'(unlink_id(lv, r.item_id));
                    if (s == NSLOT) o.status = spq_pkg::ST_MISS;
                    else
                    begin
                        o.result_id = r.item_id;
                        busy[s] = 1'b0;
                        add_wait(lv*NSPL+spq_pkg::SUM_DROPPED, r.time_now - entered[s]);
                        counts[lv*NCPL+spq_pkg::CNT_DROPPED]++;
                    end
                end
            end
            spq_pkg::KIND_SERVE:
            begin
                lv = 0;
                while (lv < nl && head[lv] == NO_SLOT) lv++;
                if (lv >= nl) o.status = spq_pkg::ST_MISS;
                else
                begin
                    s = int'(head[lv]);
                    head[lv] = nxt[s];
                    if (head[lv] == NO_SLOT) tail[lv] = NO_SLOT;
                    depth[lv] = depth[lv] - 7'd1;
                    busy[s] = 1'b0;
                    o.level = 2'(lv);
                    o.result_id = tag[s];
                    show = 1'b1;
                    add_wait(lv*NSPL+spq_pkg::SUM_SERVED, r.time_now - entered[s]);
                    counts[lv*NCPL+spq_pkg::CNT_SERVED]++;
                end
            end
            spq_pkg::KIND_MOVE:
            begin
                if (int'(r.level_from) >= nl)
                begin
                    o.status = spq_pkg::ST_BAD_LVL;
                    o.level = r.level_from;
                end
                else if (int'(r.level_to) >= nl)
                begin
                    o.status = spq_pkg::ST_BAD_LVL;
                    o.level = r.level_to;
                end
                else
                begin
                    lv = int'(r.level_from);
                    o.level = r.level_to;
                    show = 1'b1;
                    s = int'(unlink_id(lv, r.item_id));
                    if (s == NSLOT) o.status = spq_pkg::ST_MISS;
                    else
                    begin
                        o.result_id = r.item_id;
                        add_wait(lv*NSPL+spq_pkg::SUM_MOVED, r.time_now - entered[s]);
                        counts[lv*NCPL+spq_pkg::CNT_MOVED_OUT]++;
                        entered[s] = r.time_now;
                        push_tail(int'(r.level_to), 7'(s));
                        counts[int'(r.level_to)*NCPL+spq_pkg::CNT_MOVED_IN]++;
                    end
                end
            end
            spq_pkg::KIND_XFER:
            begin
                lv = int'(r.level_from);
                o.level = r.level_from;
                if (lv >= nl) o.status = spq_pkg::ST_BAD_LVL;
                else
                begin
                    show = 1'b1;
                    counts[lv*NCPL+spq_pkg::CNT_XFER_IN]++;
                    counts[lv*NCPL+spq_pkg::CNT_DROPPED]++;
                end
            end
            spq_pkg::KIND_STAT:
            begin
                lv = int'(r.level_from);
                o.level = r.level_from;
                if (lv >= nl) o.status = spq_pkg::ST_BAD_LVL;
                else
                begin
                    show = 1'b1;
                    if (r.stat_select < spq_pkg::SEL_FIRST_SUM)
                        o.stat_value = 48'(counts[lv*NCPL+int'(r.stat_select)]);
                    else if (r.stat_select < spq_pkg::SEL_END)
                        o.stat_value =
                            waits[lv*NSPL+int'(r.stat_select-spq_pkg::SEL_FIRST_SUM)];
                end
            end
            default: ;
        endcase
        if (show && int'(o.level) < NLVL) o.occupancy = depth[o.level];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        spq_pkg::rsp_t want;
        if (!rst_n)
        begin
            clear_model();
            awaited.delete();
            errors <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_NUM_LEVELS) lvl_reg = pwdata[1:0];
                else if (paddr == ADDR_BY_AGE) age_reg = pwdata[0];
            end
            if (rsp_valid && rsp_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %p", $time, rsp);
                    errors <= errors + 1;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (rsp.status !== want.status || rsp.level !== want.level ||
                        rsp.result_id !== want.result_id ||
                        rsp.occupancy !== want.occupancy ||
                        rsp.stat_value !== want.stat_value)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp);
                        errors <= errors + 1;
                    end
                end
            end
            if (req_valid && req_ready) awaited.push_back(queue_outcome(req));
        end
    end

endmodule

### tb/strict_priority_queue_with_stats_tb.sv
`timescale 1ns / 1ps

module strict_priority_queue_with_stats_tb;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE      = 200;
    localparam logic [2:0] ADDR_NUM_LEVELS = {spq_pkg::REG_NUM_LEVELS, 2'b00};
    localparam logic [2:0] ADDR_BY_AGE     = {spq_pkg::REG_LEVEL_BY_AGE, 2'b00};

    logic          clk;
    logic          rst_n;
    logic          psel, penable, pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          req_valid, req_ready;
    spq_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    spq_pkg::rsp_t rsp;
    int            errors, pending;
    int            cycles = 0;
    logic          quiet;
    logic          hold_off;
    int            hold_left = 0;
    logic [31:0]   clock_ticks;

    strict_priority_queue_with_stats dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    spq_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver keeps its own count for the long hold-off.
    always @(posedge clk)
    begin
        if (hold_off && hold_left == 0)
        begin
            hold_left <= 400;
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= quiet || ($urandom_range(99) >= 7);
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle_and_configure(logic [1:0] levels, logic by_age);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        reg_write(ADDR_NUM_LEVELS, {30'($urandom), levels});
        reg_write(ADDR_BY_AGE, {31'($urandom), by_age});
        @(posedge clk);
    endtask

    task automatic offer(spq_pkg::req_t r);
        while (!quiet && $urandom_range(99) < 7)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    function automatic spq_pkg::req_t command(logic [2:0] k, logic [15:0] id,
                                              logic [1:0] a, logic [1:0] s,
                                              logic [1:0] lf, logic [1:0] lt,
                                              logic [3:0] sel);
        spq_pkg::req_t r;
        r = '0;
        r.kind = k;
        r.item_id = id;
        r.age_class = a;
        r.severity = s;
        r.source = 2'($urandom);
        r.level_from = lf;
        r.level_to = lt;
        r.time_now = clock_ticks;
        r.stat_select = sel;
        return r;
    endfunction

    function automatic logic [1:0] pick_level();
        return ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(2));
    endfunction

    // Mostly plausible commands on a small id range so drops and moves hit.
    function automatic spq_pkg::req_t random_command(int insert_pct);
        spq_pkg::req_t r;
        int roll;
        logic [2:0] k;
        roll = $urandom_range(99);
        if (roll < insert_pct) k = spq_pkg::KIND_INSERT;
        else if (roll < insert_pct + (100 - insert_pct) * 25 / 100) k = spq_pkg::KIND_DROP;
        else if (roll < insert_pct + (100 - insert_pct) * 50 / 100) k = spq_pkg::KIND_SERVE;
        else if (roll < insert_pct + (100 - insert_pct) * 70 / 100) k = spq_pkg::KIND_MOVE;
        else if (roll < insert_pct + (100 - insert_pct) * 78 / 100) k = spq_pkg::KIND_XFER;
        else if (roll < 97) k = spq_pkg::KIND_STAT;
        else k = 3'($urandom_range(7));
        r = command(k, ($urandom_range(99) < 85) ? 16'($urandom_range(31)) : 16'($urandom),
                    pick_level(), pick_level(), pick_level(), pick_level(),
                    4'($urandom));
        if ($urandom_range(99) < 3) r.time_now = $urandom;
        return r;
    endfunction

    task automatic random_phase(int n, int insert_pct);
        for (int i = 0; i < n; i++)
        begin
            clock_ticks = clock_ticks + $urandom_range(5000);
            offer(random_command(insert_pct));
        end
        req_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        req = '0;
        quiet = 1'b0;
        hold_off = 1'b0;
        clock_ticks = 32'hFFFF_F000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, field extremes, bad levels and wrapping waits.
        offer(command(spq_pkg::KIND_SERVE, 16'h0, 2'd0, 2'd0, 2'd0, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_STAT, 16'h0, 2'd0, 2'd0, 2'd2, 2'd0, 4'd15));
        offer(command(spq_pkg::KIND_DROP, 16'h5, 2'd0, 2'd0, 2'd1, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_INSERT, 16'hFFFF, 2'd3, 2'd0, 2'd0, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_INSERT, 16'h0000, 2'd0, 2'd1, 2'd0, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_INSERT, 16'h0000, 2'd0, 2'd2, 2'd0, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_INSERT, 16'h1234, 2'd0, 2'd3, 2'd0, 2'd0, 4'd0));
        clock_ticks = 32'h0000_0100;
        offer(command(spq_pkg::KIND_MOVE, 16'h0000, 2'd0, 2'd0, 2'd1, 2'd1, 4'd0));
        offer(command(spq_pkg::KIND_MOVE, 16'h0000, 2'd0, 2'd0, 2'd3, 2'd1, 4'd0));
        offer(command(spq_pkg::KIND_MOVE, 16'h0000, 2'd0, 2'd0, 2'd1, 2'd3, 4'd0));
        offer(command(spq_pkg::KIND_MOVE, 16'hFFFF, 2'd0, 2'd0, 2'd0, 2'd2, 4'd0));
        offer(command(spq_pkg::KIND_DROP, 16'h0000, 2'd0, 2'd0, 2'd2, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_DROP, 16'h0000, 2'd0, 2'd0, 2'd3, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_XFER, 16'h0000, 2'd0, 2'd0, 2'd1, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_XFER, 16'h0000, 2'd0, 2'd0, 2'd3, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_STAT, 16'h0000, 2'd0, 2'd0, 2'd1, 2'd0, 4'd4));
        offer(command(spq_pkg::KIND_STAT, 16'h0000, 2'd0, 2'd0, 2'd1, 2'd0, 4'd8));
        offer(command(spq_pkg::KIND_STAT, 16'h0000, 2'd0, 2'd0, 2'd2, 2'd0, 4'd7));
        offer(command(3'd6, 16'hFFFF, 2'd3, 2'd3, 2'd3, 2'd3, 4'd15));
        offer(command(3'd7, 16'hFFFF, 2'd3, 2'd3, 2'd3, 2'd3, 4'd15));
        offer(command(spq_pkg::KIND_SERVE, 16'h0, 2'd0, 2'd0, 2'd0, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_SERVE, 16'h0, 2'd0, 2'd0, 2'd0, 2'd0, 4'd0));
        offer(command(spq_pkg::KIND_STAT, 16'h0000, 2'd0, 2'd0, 2'd0, 2'd0, 4'd6));
        req_valid <= 1'b0;

        // Long receiver hold-off with the sender still pushing.
        settle_and_configure(2'd3, 1'b1);
        hold_off <= 1'b1;
        @(posedge clk);
        hold_off <= 1'b0;
        random_phase(120, 40);

        // Insert-heavy so the store runs full.
        settle_and_configure(2'd3, 1'b0);
        random_phase(160, 75);

        settle_and_configure(2'd1, 1'b1);
        quiet <= 1'b1;
        random_phase(120, 45);
        quiet <= 1'b0;

        settle_and_configure(2'd2, 1'b1);
        random_phase(140, 45);

        settle_and_configure(2'd0, 1'b0);
        random_phase(100, 45);

        settle_and_configure(2'd2, 1'b0);
        random_phase(140, 45);

        settle_and_configure(2'd3, 1'b1);
        random_phase(200, 40);

        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
src/spq_pkg.sv
src/strict_priority_queue_with_stats.sv
tb/spq_checker.sv
tb/strict_priority_queue_with_stats_tb.sv
